### rtl/hufd_pkg.sv
// Shared types and codes for the Huffman tree decoder.
`default_nettype none

package hufd_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_DECODE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_SYMBOL  = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [3:0] BYTE_BITS  = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_STEP,
    S_LD_READ,
    S_LD_INIT,
    S_DC_LOAD,
    S_DC_STEP,
    S_DC_EVAL,
    S_DC_END
  } hufd_state_t;

endpackage

`default_nettype wire

### rtl/huffman_tree_decoder.sv
// Huffman tree decoder: code table built into a node memory, bitwise tree walk.
`default_nettype none

// One item at a time; busy is high while an item is in work. The tree lives
// in a node memory (left/right child pair per node) and a symbol memory, both
// with registered reads; the root's children sit in registers. Each decode
// tree step is a memory read followed by an evaluate state; a load step reads
// the existing child and latches it, or hooks a new node and then clears it.
// Clear and ignored items finish in the accept cycle. Results appear with
// result_strobe and cannot be held off; last marks the final result of an
// item. Results of a decode byte are held back one result in a one-deep
// buffer so that last can be set; the final one is sent from the end state.
module huffman_tree_decoder #(
  parameter int SYMBOL_COUNT = 256,
  parameter int NODE_COUNT   = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  code_symbol,
  input  logic [5:0]  code_length,
  input  logic [31:0] code_bits,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  valid_bits,
  input  logic        final_byte,
  output logic        result_strobe,
  output logic [7:0]  decoded_symbol,
  output logic [1:0]  status,
  output logic        last
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = NW + 1;
  localparam logic [CW-1:0] NODE_LIMIT = CW'(NODE_COUNT);
  localparam logic [8:0]    SYM_LIMIT  = 9'(SYMBOL_COUNT);
  localparam logic [6:0]    LEN_LIMIT  = 7'(MAX_CODE_LEN);

  hufd_pkg::hufd_state_t state, state_next;

  // node memory: {left, right}
  logic [2*NW-1:0] node_mem [NODE_COUNT];
  logic [7:0]      sym_mem  [NODE_COUNT];

  logic            nm_we;
  logic [NW-1:0]   nm_waddr;
  logic [2*NW-1:0] nm_wdata;
  logic            sm_we;
  logic [NW-1:0]   sm_waddr;
  logic [7:0]      sm_wdata;
  logic [NW-1:0]   rd_addr;
  logic [NW-1:0]   mem_l, mem_r;
  logic [7:0]      sym_q;

  logic [7:0]    sym_r, sym_r_next;
  logic [5:0]    rem, rem_next;
  logic [31:0]   bits_r, bits_r_next;
  logic [7:0]    data_r, data_r_next;
  logic [3:0]    cnt, cnt_next;
  logic          fin_r, fin_r_next;
  logic [NW-1:0] node, node_next;
  logic [NW-1:0] cur_l, cur_l_next, cur_r, cur_r_next;
  logic [NW-1:0] root_l, root_l_next, root_r, root_r_next;
  logic [NW-1:0] walk, walk_next;
  logic [CW-1:0] nfree, nfree_next;
  logic          halted, halted_next;
  logic          pend_valid, pend_valid_next;
  logic [7:0]    pend_sym, pend_sym_next;
  logic [1:0]    pend_status, pend_status_next;
  logic          result_strobe_next, last_next;
  logic [7:0]    decoded_symbol_next;
  logic [1:0]    status_next;

  logic          new_res, flush;
  logic [7:0]    new_sym;
  logic [1:0]    new_status;
  logic [5:0]    pos;
  logic          ld_bit, dc_bit;
  logic [NW-1:0] ld_slot, dc_child, fresh;
  logic          load_ok;

  assign busy    = (state != hufd_pkg::S_IDLE);
  assign pos     = rem - 6'd1;
  assign ld_bit  = !pos[5] && bits_r[pos[4:0]];
  assign ld_slot = ld_bit ? cur_r : cur_l;
  assign dc_bit  = data_r[7];
  assign dc_child = dc_bit ? cur_r : cur_l;
  assign fresh   = nfree[NW-1:0];
  assign load_ok = (code_length != 6'd0) && ({1'b0, code_length} <= LEN_LIMIT) &&
                   ({1'b0, code_symbol} < SYM_LIMIT);

  always_ff @(posedge clk) begin
    if (nm_we) begin
      node_mem[nm_waddr] <= nm_wdata;
    end
    if (sm_we) begin
      sym_mem[sm_waddr] <= sm_wdata;
    end
    {mem_l, mem_r} <= node_mem[rd_addr];
    sym_q <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hufd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_l        <= '0;
      root_r        <= '0;
      walk          <= '0;
      nfree         <= CW'(1);
      halted        <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      root_l        <= root_l_next;
      root_r        <= root_r_next;
      walk          <= walk_next;
      nfree         <= nfree_next;
      halted        <= halted_next;
      pend_valid    <= pend_valid_next;
      result_strobe <= result_strobe_next;
    end
    sym_r          <= sym_r_next;
    rem            <= rem_next;
    bits_r         <= bits_r_next;
    data_r         <= data_r_next;
    cnt            <= cnt_next;
    fin_r          <= fin_r_next;
    node           <= node_next;
    cur_l          <= cur_l_next;
    cur_r          <= cur_r_next;
    pend_sym       <= pend_sym_next;
    pend_status    <= pend_status_next;
    decoded_symbol <= decoded_symbol_next;
    status         <= status_next;
    last           <= last_next;
  end

  always_comb begin
    state_next  = state;
    sym_r_next  = sym_r;
    rem_next    = rem;
    bits_r_next = bits_r;
    data_r_next = data_r;
    cnt_next    = cnt;
    fin_r_next  = fin_r;
    node_next   = node;
    cur_l_next  = cur_l;
    cur_r_next  = cur_r;
    root_l_next = root_l;
    root_r_next = root_r;
    walk_next   = walk;
    nfree_next  = nfree;
    halted_next = halted;
    pend_valid_next  = pend_valid;
    pend_sym_next    = pend_sym;
    pend_status_next = pend_status;
    result_strobe_next  = 1'b0;
    decoded_symbol_next = decoded_symbol;
    status_next         = status;
    last_next           = last;
    nm_we    = 1'b0;
    nm_waddr = node;
    nm_wdata = '0;
    sm_we    = 1'b0;
    sm_waddr = node;
    sm_wdata = '0;
    rd_addr  = node;
    new_res    = 1'b0;
    new_sym    = 8'd0;
    new_status = hufd_pkg::ST_SYMBOL;
    flush      = 1'b0;

    case (state)
      hufd_pkg::S_IDLE: begin
        if (start) begin
          case (action)
            hufd_pkg::ACT_LOAD: begin
              if (load_ok) begin
                sym_r_next  = code_symbol;
                rem_next    = code_length;
                bits_r_next = code_bits;
                node_next   = '0;
                cur_l_next  = root_l;
                cur_r_next  = root_r;
                state_next  = hufd_pkg::S_LD_STEP;
              end
            end
            hufd_pkg::ACT_DECODE: begin
              data_r_next = data_byte;
              cnt_next    = (valid_bits > hufd_pkg::BYTE_BITS) ? hufd_pkg::BYTE_BITS
                                                               : valid_bits;
              fin_r_next  = final_byte;
              if (halted) begin
                if (final_byte) begin
                  walk_next   = '0;
                  halted_next = 1'b0;
                end
              end else if (walk == '0) begin
                cur_l_next = root_l;
                cur_r_next = root_r;
                state_next = hufd_pkg::S_DC_STEP;
              end else begin
                rd_addr    = walk;
                state_next = hufd_pkg::S_DC_LOAD;
              end
            end
            hufd_pkg::ACT_CLEAR: begin
              root_l_next = '0;
              root_r_next = '0;
              walk_next   = '0;
              nfree_next  = CW'(1);
              halted_next = 1'b0;
            end
            default: ;
          endcase
        end
      end

      hufd_pkg::S_LD_STEP: begin
        if (rem == 6'd0) begin
          sm_we      = 1'b1;
          sm_waddr   = node;
          sm_wdata   = sym_r;
          state_next = hufd_pkg::S_IDLE;
        end else if (ld_slot != '0) begin
          rd_addr    = ld_slot;
          node_next  = ld_slot;
          rem_next   = rem - 6'd1;
          state_next = hufd_pkg::S_LD_READ;
        end else if (nfree == NODE_LIMIT) begin
          result_strobe_next  = 1'b1;
          decoded_symbol_next = 8'd0;
          status_next         = hufd_pkg::ST_FULL;
          last_next           = 1'b1;
          state_next          = hufd_pkg::S_IDLE;
        end else begin
          // hook the new node under its parent, parent entry is in cur
          if (node == '0) begin
            if (ld_bit) begin
              root_r_next = fresh;
            end else begin
              root_l_next = fresh;
            end
          end else begin
            nm_we    = 1'b1;
            nm_waddr = node;
            nm_wdata = ld_bit ? {cur_l, fresh} : {fresh, cur_r};
          end
          nfree_next = nfree + CW'(1);
          node_next  = fresh;
          cur_l_next = '0;
          cur_r_next = '0;
          rem_next   = rem - 6'd1;
          state_next = hufd_pkg::S_LD_INIT;
        end
      end

      hufd_pkg::S_LD_READ: begin
        cur_l_next = mem_l;
        cur_r_next = mem_r;
        state_next = hufd_pkg::S_LD_STEP;
      end

      hufd_pkg::S_LD_INIT: begin
        nm_we      = 1'b1;
        nm_waddr   = node;
        nm_wdata   = '0;
        sm_we      = 1'b1;
        sm_waddr   = node;
        sm_wdata   = 8'd0;
        state_next = hufd_pkg::S_LD_STEP;
      end

      hufd_pkg::S_DC_LOAD: begin
        cur_l_next = mem_l;
        cur_r_next = mem_r;
        state_next = hufd_pkg::S_DC_STEP;
      end

      hufd_pkg::S_DC_STEP: begin
        if (cnt == 4'd0) begin
          state_next = hufd_pkg::S_DC_END;
        end else if (dc_child == '0) begin
          new_res     = 1'b1;
          new_status  = hufd_pkg::ST_MISSING;
          halted_next = 1'b1;
          walk_next   = '0;
          state_next  = hufd_pkg::S_DC_END;
        end else begin
          rd_addr     = dc_child;
          node_next   = dc_child;
          data_r_next = {data_r[6:0], 1'b0};
          cnt_next    = cnt - 4'd1;
          state_next  = hufd_pkg::S_DC_EVAL;
        end
      end

      hufd_pkg::S_DC_EVAL: begin
        if (mem_l == '0 && mem_r == '0) begin
          new_res    = 1'b1;
          new_sym    = sym_q;
          walk_next  = '0;
          cur_l_next = root_l;
          cur_r_next = root_r;
        end else begin
          walk_next  = node;
          cur_l_next = mem_l;
          cur_r_next = mem_r;
        end
        state_next = hufd_pkg::S_DC_STEP;
      end

      hufd_pkg::S_DC_END: begin
        flush = 1'b1;
        if (fin_r) begin
          walk_next   = '0;
          halted_next = 1'b0;
        end
        state_next = hufd_pkg::S_IDLE;
      end

      default: state_next = hufd_pkg::S_IDLE;
    endcase

    // one-deep hold so the final beat of a byte can carry last
    if (new_res) begin
      if (pend_valid) begin
        result_strobe_next  = 1'b1;
        decoded_symbol_next = pend_sym;
        status_next         = pend_status;
        last_next           = 1'b0;
      end
      pend_valid_next  = 1'b1;
      pend_sym_next    = new_sym;
      pend_status_next = new_status;
    end else if (flush) begin
      if (pend_valid) begin
        result_strobe_next  = 1'b1;
        decoded_symbol_next = pend_sym;
        status_next         = pend_status;
        last_next           = 1'b1;
      end
      pend_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/hufd_checker.sv
// Port-level checks for the Huffman tree decoder, bound to the top level.
`default_nettype none

module hufd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        result_strobe,
  input wire logic [7:0]  decoded_symbol,
  input wire logic [1:0]  status,
  input wire logic        last
);

  // a full store ends the load at once
  ap_full_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == hufd_pkg::ST_FULL |-> last && decoded_symbol == 8'd0)
    else $error("store-full beat not last or symbol nonzero");

  // a missing branch drops the rest of the byte
  ap_miss_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == hufd_pkg::ST_MISSING |-> last && decoded_symbol == 8'd0)
    else $error("missing-branch beat not last or symbol nonzero");

  ap_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("non-last beat while idle");

  ap_from_work: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("beat without an item in work");

endmodule

bind huffman_tree_decoder hufd_checker u_hufd_checker (.*);

`default_nettype wire
